/* design/weighted_class_sampler_no_replace_core_assert.svh */
// assertion helpers, clk / arst_n taken from the enclosing module
`ifndef WEIGHTED_CLASS_SAMPLER_NO_REPLACE_CORE_ASSERT_SVH
`define WEIGHTED_CLASS_SAMPLER_NO_REPLACE_CORE_ASSERT_SVH

// condition holds at every edge out of reset
`define WCS_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define WCS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* design/wcs_pkg.sv */
package wcs_pkg;

	localparam int MAX_CLASSES = 64;
	localparam int ID_BITS     = 6;
	localparam int LOAD_BITS   = 7;
	localparam int W_BITS      = 33;
	localparam int COUNT_BITS  = 16;
	localparam int TALLY_BITS  = 32;
	localparam int RAND_BITS   = 32;
	localparam int MASS_BITS   = W_BITS + ID_BITS;

	localparam logic [W_BITS-1:0] WONE = {1'b1, {(W_BITS-1){1'b0}}};

	typedef enum logic [1:0] {
		MODE_CLEAR = 2'd0,
		MODE_LOAD  = 2'd1,
		MODE_DRAW  = 2'd2,
		MODE_TALLY = 2'd3
	} mode_t;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_FULL   = 2'd1;
	localparam logic [1:0] STATUS_NOMASS = 2'd3;

	localparam logic REG_DPS = 1'b0;

	typedef struct packed {
		logic [W_BITS-1:0]     weight;
		logic [COUNT_BITS-1:0] members;
		logic [ID_BITS-1:0]    ident;
	} entry_t;

endpackage

/* design/weighted_class_sampler_no_replace_core.sv */
// channel   | handshake            | payload
// in        | in_valid / in_stall  | mode, class_id, class_weight, class_count, random_fraction
// out       | out_valid / out_stall| picked_class, tally_count, status, last_draw, last_sample
// cfg       | cfg_we               | cfg_index, cfg_data
// Clear and rejected requests go straight to TALLY_WR; a tally read passes TALLY_RD first.
// Load shifts each lighter entry down the master table, then ends through TALLY_RD and TALLY_WR.
// Draw: a table copy on the first draw of a sample, a cumulative walk over the loaded
// classes, the serial divider, then the weight update and an optional swap.
// Async active-low reset; tables hold garbage until loaded, tallies read as zero.
// in_stall is high while a request is in work or its finished result has not yet moved to the output register.
`include "weighted_class_sampler_no_replace_core_assert.svh"

module weighted_class_sampler_no_replace_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [5:0]  class_id,
	input  logic [32:0] class_weight,
	input  logic [15:0] class_count,
	input  logic [31:0] random_fraction,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [5:0]  picked_class,
	output logic [31:0] tally_count,
	output logic [1:0]  status,
	output logic        last_draw,
	output logic        last_sample
);
	import wcs_pkg::*;

	typedef enum logic [13:0] {
		ST_IDLE     = 14'b00000000000001,
		ST_COPY     = 14'b00000000000010,
		ST_SCALE    = 14'b00000000000100,
		ST_TARGET   = 14'b00000000001000,
		ST_WALK     = 14'b00000000010000,
		ST_RD_SEL   = 14'b00000000100000,
		ST_RD_NXT   = 14'b00000001000000,
		ST_DIVS     = 14'b00000010000000,
		ST_DIV      = 14'b00000100000000,
		ST_UPD      = 14'b00001000000000,
		ST_SWAP     = 14'b00010000000000,
		ST_TALLY_RD = 14'b00100000000000,
		ST_TALLY_WR = 14'b01000000000000,
		ST_LOAD     = 14'b10000000000000
	} state_t;

	state_t state_q;
	logic   load_ev_q;

	logic [15:0] dps_q, stt_q, dps_eff, stt_eff;
	logic [LOAD_BITS-1:0] loaded_q, idx_q, idx_m1;
	logic [W_BITS-1:0] rem_q, cur_rem_q, target_q;
	logic [15:0] draw_q, sample_q, draw_nx, sample_nx;
	logic [1:0] mode_q;
	logic [ID_BITS-1:0] id_q, sel_q, lastnz_q, sel_eff;
	logic [RAND_BITS-1:0] r_q;
	entry_t new_q, ent_q, nxt_q, upd_ent;
	logic [63:0] prod_q;
	logic [MASS_BITS-1:0] mass_q, mass_nx;
	logic found_q, anynz_q;

	logic [ID_BITS-1:0] res_pick_q, out_pick_q;
	logic [TALLY_BITS-1:0] res_tally_q, out_tally_q;
	logic [1:0] res_status_q, out_status_q;
	logic res_ld_q, res_ls_q, out_ld_q, out_ls_q, out_valid_q;
	// a finished result not yet moved to the output register
	logic res_ready_q;

	entry_t master_mem [MAX_CLASSES];
	entry_t work_mem [MAX_CLASSES];
	logic [TALLY_BITS-1:0] tally_mem [MAX_CLASSES];
	logic [MAX_CLASSES-1:0] tally_vld_q;
	entry_t master_rd_q, work_rd_q, master_wdata, work_wdata;
	logic [TALLY_BITS-1:0] tally_rd_q, tally_cur, tally_inc;
	logic [ID_BITS-1:0] master_raddr, master_waddr, work_raddr, work_waddr, tally_addr;
	logic master_we, work_we, tally_we;

	logic div_busy;
	logic [W_BITS-1:0] div_quot, share, upd_w;
	logic swap, out_free, walk_hit;

	wcs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_DIVS),
		.dividend (ent_q.weight),
		.divisor  (ent_q.members),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	assign dps_eff  = (dps_q == '0) ? 16'd1 : dps_q;
	assign stt_eff  = (stt_q == '0) ? 16'd1 : stt_q;
	assign idx_m1   = idx_q - LOAD_BITS'(1);
	assign sel_eff  = found_q ? sel_q : lastnz_q;
	assign mass_nx  = mass_q + MASS_BITS'(work_rd_q.weight);
	assign walk_hit = MASS_BITS'(target_q) <= mass_nx;

	assign share   = (ent_q.members == '0) ? ent_q.weight : div_quot;
	assign upd_w   = ent_q.weight - share;
	assign upd_ent = '{weight: upd_w,
		members: (ent_q.members == '0) ? ent_q.members : ent_q.members - 16'd1,
		ident: ent_q.ident};
	assign swap    = ((LOAD_BITS'(sel_q) + LOAD_BITS'(1)) < loaded_q)
		&& (upd_w < nxt_q.weight);

	assign tally_cur = tally_vld_q[tally_addr] ? tally_rd_q : '0;
	assign tally_inc = (tally_cur == '1) ? tally_cur : tally_cur + TALLY_BITS'(1);
	assign draw_nx   = draw_q + 16'd1;
	assign sample_nx = sample_q + 16'd1;
	assign out_free  = !out_valid_q || !out_stall;

	always_comb begin
		master_raddr = (state_q == ST_COPY) ? idx_q[ID_BITS-1:0] : idx_m1[ID_BITS-1:0];
		master_we    = 1'b0;
		master_waddr = idx_q[ID_BITS-1:0];
		master_wdata = new_q;
		work_we      = 1'b0;
		work_waddr   = sel_q;
		work_wdata   = ent_q;
		work_raddr   = idx_q[ID_BITS-1:0];
		tally_we     = 1'b0;
		tally_addr   = (mode_q == MODE_DRAW) ? ent_q.ident : id_q;
		unique case (state_q)
			ST_COPY: begin
				work_we    = idx_q != '0;
				work_waddr = idx_m1[ID_BITS-1:0];
				work_wdata = master_rd_q;
			end
			ST_RD_SEL: work_raddr = sel_eff;
			ST_RD_NXT: work_raddr = sel_q + ID_BITS'(1);
			ST_UPD: begin
				work_we    = 1'b1;
				work_wdata = swap ? nxt_q : upd_ent;
			end
			ST_SWAP: begin
				work_we    = 1'b1;
				work_waddr = sel_q + ID_BITS'(1);
			end
			ST_LOAD: begin
				if (!load_ev_q)
					master_we = idx_q == '0;
				else begin
					master_we = 1'b1;
					if (master_rd_q.weight < new_q.weight)
						master_wdata = master_rd_q;
				end
			end
			ST_TALLY_WR: tally_we = (mode_q == MODE_DRAW) && (res_status_q == STATUS_OK);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		master_rd_q <= master_mem[master_raddr];
		if (master_we)
			master_mem[master_waddr] <= master_wdata;
	end

	always_ff @(posedge clk) begin
		work_rd_q <= work_mem[work_raddr];
		if (work_we)
			work_mem[work_waddr] <= work_wdata;
	end

	always_ff @(posedge clk) begin
		tally_rd_q <= tally_mem[tally_addr];
		if (tally_we)
			tally_mem[tally_addr] <= tally_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dps_q <= 16'd1;
			stt_q <= 16'd1;
		end else if (cfg_we) begin
			if (cfg_index == REG_DPS)
				dps_q <= cfg_data;
			else
				stt_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			load_ev_q    <= 1'b0;
			loaded_q     <= '0;
			rem_q        <= WONE;
			draw_q       <= '0;
			sample_q     <= '0;
			tally_vld_q  <= '0;
			mode_q       <= MODE_CLEAR;
			id_q         <= '0;
			r_q          <= '0;
			new_q        <= '0;
			ent_q        <= '0;
			nxt_q        <= '0;
			idx_q        <= '0;
			cur_rem_q    <= '0;
			prod_q       <= '0;
			target_q     <= '0;
			mass_q       <= '0;
			found_q      <= 1'b0;
			anynz_q      <= 1'b0;
			sel_q        <= '0;
			lastnz_q     <= '0;
			res_pick_q   <= '0;
			res_tally_q  <= '0;
			res_status_q <= STATUS_OK;
			res_ld_q     <= 1'b0;
			res_ls_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && !in_stall) begin
						mode_q       <= mode;
						id_q         <= class_id;
						r_q          <= random_fraction;
						new_q        <= '{weight: (class_weight > WONE) ? WONE : class_weight,
							members: class_count, ident: class_id};
						res_pick_q   <= '0;
						res_tally_q  <= '0;
						res_status_q <= STATUS_OK;
						res_ld_q     <= 1'b0;
						res_ls_q     <= 1'b0;
						mass_q       <= '0;
						found_q      <= 1'b0;
						anynz_q      <= 1'b0;
						sel_q        <= '0;
						lastnz_q     <= '0;
						case (mode)
							MODE_CLEAR: begin
								loaded_q    <= '0;
								rem_q       <= WONE;
								draw_q      <= '0;
								sample_q    <= '0;
								tally_vld_q <= '0;
								state_q     <= ST_TALLY_WR;
							end
							MODE_LOAD: begin
								if (loaded_q >= LOAD_BITS'(MAX_CLASSES)) begin
									res_status_q <= STATUS_FULL;
									state_q      <= ST_TALLY_WR;
								end else begin
									idx_q     <= loaded_q;
									load_ev_q <= 1'b0;
									state_q   <= ST_LOAD;
								end
							end
							MODE_DRAW: begin
								idx_q     <= '0;
								cur_rem_q <= (draw_q == '0) ? WONE : rem_q;
								if (sample_q >= stt_eff) begin
									res_status_q <= STATUS_NOMASS;
									state_q      <= ST_TALLY_WR;
								end else
									state_q <= (draw_q == '0) ? ST_COPY : ST_SCALE;
							end
							default: state_q <= ST_TALLY_RD;
						endcase
					end
				end
				ST_COPY: begin
					if (idx_q == loaded_q)
						state_q <= ST_SCALE;
					else
						idx_q <= idx_q + LOAD_BITS'(1);
				end
				ST_SCALE: begin
					prod_q  <= cur_rem_q[RAND_BITS-1:0] * r_q;
					state_q <= ST_TARGET;
				end
				ST_TARGET: begin
					target_q <= (cur_rem_q[W_BITS-1] ? W_BITS'(r_q) : '0)
						+ W_BITS'(prod_q[63:32]);
					idx_q    <= '0;
					state_q  <= ST_WALK;
				end
				ST_WALK: begin
					if (idx_q != '0 && work_rd_q.weight != '0) begin
						anynz_q  <= 1'b1;
						lastnz_q <= idx_m1[ID_BITS-1:0];
						mass_q   <= mass_nx;
						if (!found_q && walk_hit) begin
							found_q <= 1'b1;
							sel_q   <= idx_m1[ID_BITS-1:0];
						end
					end
					if (idx_q == loaded_q)
						state_q <= ST_RD_SEL;
					else
						idx_q <= idx_q + LOAD_BITS'(1);
				end
				ST_RD_SEL: begin
					if (!anynz_q) begin
						res_status_q <= STATUS_NOMASS;
						state_q      <= ST_TALLY_WR;
					end else begin
						sel_q   <= sel_eff;
						state_q <= ST_RD_NXT;
					end
				end
				ST_RD_NXT: begin
					ent_q   <= work_rd_q;
					state_q <= ST_DIVS;
				end
				ST_DIVS: begin
					nxt_q   <= work_rd_q;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (!div_busy)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					ent_q   <= upd_ent;
					rem_q   <= (cur_rem_q > share) ? cur_rem_q - share : '0;
					state_q <= swap ? ST_SWAP : ST_TALLY_RD;
				end
				ST_SWAP: state_q <= ST_TALLY_RD;
				ST_TALLY_RD: state_q <= ST_TALLY_WR;
				ST_TALLY_WR: begin
					if (mode_q == MODE_DRAW && res_status_q == STATUS_OK) begin
						tally_vld_q[tally_addr] <= 1'b1;
						res_tally_q <= tally_inc;
						res_pick_q  <= ent_q.ident;
						if (draw_nx == '0 || draw_nx >= dps_eff) begin
							res_ld_q <= 1'b1;
							draw_q   <= '0;
							sample_q <= sample_nx;
							res_ls_q <= sample_nx >= stt_eff;
						end else
							draw_q <= draw_nx;
					end else if (mode_q == MODE_TALLY)
						res_tally_q <= tally_cur;
					state_q <= ST_IDLE;
				end
				ST_LOAD: begin
					if (!load_ev_q) begin
						if (idx_q == '0) begin
							loaded_q <= loaded_q + LOAD_BITS'(1);
							draw_q   <= '0;
							state_q  <= ST_TALLY_RD;
						end else
							load_ev_q <= 1'b1;
					end else begin
						load_ev_q <= 1'b0;
						if (master_rd_q.weight < new_q.weight)
							idx_q <= idx_m1;
						else begin
							loaded_q <= loaded_q + LOAD_BITS'(1);
							draw_q   <= '0;
							state_q  <= ST_TALLY_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result staging: TALLY_WR closes every request; output register holds it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_pick_q   <= '0;
			out_tally_q  <= '0;
			out_status_q <= STATUS_OK;
			out_ld_q     <= 1'b0;
			out_ls_q     <= 1'b0;
		end else if (state_q == ST_IDLE && res_ready_q && out_free) begin
			out_valid_q  <= 1'b1;
			out_pick_q   <= res_pick_q;
			out_tally_q  <= res_tally_q;
			out_status_q <= res_status_q;
			out_ld_q     <= res_ld_q;
			out_ls_q     <= res_ls_q;
		end else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_ready_q <= 1'b0;
		else if (state_q == ST_TALLY_WR)
			res_ready_q <= 1'b1;
		else if (state_q == ST_IDLE && out_free)
			res_ready_q <= 1'b0;
	end

	assign in_stall     = (state_q != ST_IDLE) || res_ready_q;
	assign out_valid    = out_valid_q;
	assign picked_class = out_pick_q;
	assign tally_count  = out_tally_q;
	assign status       = out_status_q;
	assign last_draw    = out_ld_q;
	assign last_sample  = out_ls_q;

	`WCS_ASSERT(a_loaded_max, loaded_q <= LOAD_BITS'(MAX_CLASSES), "class count above table size")
	`WCS_ASSERT(a_rem_max, rem_q <= WONE, "remaining mass above one")
	`WCS_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_q != ST_IDLE, "request accepted but sequencer idle")
	`WCS_ASSERT(a_div_owned, !div_busy || state_q == ST_DIV, "divider busy outside divide step")

endmodule

/* design/wcs_div.sv */
module wcs_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [wcs_pkg::W_BITS-1:0]      dividend,
	input  logic [wcs_pkg::COUNT_BITS-1:0]  divisor,
	output logic                            busy,
	output logic [wcs_pkg::W_BITS-1:0]      quot
);
	import wcs_pkg::*;

	logic                  busy_q;
	logic [5:0]            cnt_q;
	logic [W_BITS-1:0]     num_q;
	logic [COUNT_BITS-1:0] part_q;
	logic [COUNT_BITS-1:0] den_q;
	logic [COUNT_BITS:0]   trial;
	logic                  fits;

	// restoring, one quotient bit per cycle
	assign trial = {part_q, num_q[W_BITS-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			num_q  <= '0;
			part_q <= '0;
			den_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'(W_BITS - 1);
			num_q  <= dividend;
			part_q <= '0;
			den_q  <= divisor;
		end else if (busy_q) begin
			part_q <= fits ? COUNT_BITS'(trial - {1'b0, den_q}) : trial[COUNT_BITS-1:0];
			num_q  <= {num_q[W_BITS-2:0], fits};
			cnt_q  <= cnt_q - 6'd1;
			if (cnt_q == '0)
				busy_q <= 1'b0;
		end
	end

	assign busy = busy_q;
	assign quot = num_q;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
	import wcs_pkg::*;

	localparam logic REG_SAMPLES = 1'b1;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LONG_HOLD = 600;

	typedef struct {
		mode_t       mode;
		logic [5:0]  id;
		logic [32:0] weight;
		logic [15:0] count;
		logic [31:0] frac;
	} request_t;

	typedef struct {
		logic [5:0]  picked;
		logic [31:0] tally;
		logic [1:0]  status;
		logic        last_draw;
		logic        last_sample;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  mode = '0;
	logic [5:0]  class_id = '0;
	logic [32:0] class_weight = '0;
	logic [15:0] class_count = '0;
	logic [31:0] random_fraction = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [5:0]  picked_class;
	logic [31:0] tally_count;
	logic [1:0]  status;
	logic        last_draw;
	logic        last_sample;

	weighted_class_sampler_no_replace_core dut (.*);

	initial begin
		forever #4 clk = ~clk;
	end

	// predictor state
	logic [32:0] m_weight [MAX_CLASSES];
	logic [15:0] m_members [MAX_CLASSES];
	logic [5:0]  m_ident [MAX_CLASSES];
	logic [32:0] w_weight [MAX_CLASSES];
	logic [15:0] w_members [MAX_CLASSES];
	logic [5:0]  w_ident [MAX_CLASSES];
	logic [31:0] tallies [MAX_CLASSES];
	int          n_loaded;
	logic [32:0] mass_left;
	logic [15:0] draw_pos, sample_pos;
	logic [15:0] draws_cfg = 16'd1, samples_cfg = 16'd1;

	request_t pending_reqs[$];
	outcome_t expected_outcomes[$];
	int sent_cnt = 0, accepted_cnt = 0, results_cnt = 0;
	int errors = 0, idle_cycles = 0;
	int n_picks = 0, n_nomass = 0, n_full = 0, n_last_sample = 0, n_loads = 0;

	function automatic void clear_sampler();
		for (int i = 0; i < MAX_CLASSES; i++)
			tallies[i] = '0;
		n_loaded = 0;
		mass_left = WONE;
		draw_pos = '0;
		sample_pos = '0;
	endfunction

	function automatic outcome_t predict_sampler(request_t q);
		outcome_t o;
		logic [15:0] dps, stt, m;
		logic [32:0] w, share, tw, rem;
		logic [15:0] tm;
		logic [5:0]  ti, cid;
		logic [64:0] prod;
		logic [39:0] target, acc;
		int sel, lastnz;
		bit found, anynz;
		o = '{default: '0};
		o.status = STATUS_OK;
		dps = draws_cfg == 0 ? 16'd1 : draws_cfg;
		stt = samples_cfg == 0 ? 16'd1 : samples_cfg;
		case (q.mode)
			MODE_CLEAR: clear_sampler();
			MODE_LOAD: begin
				if (n_loaded >= MAX_CLASSES) begin
					o.status = STATUS_FULL;
				end else begin
					int pos;
					w = q.weight > WONE ? WONE : q.weight;
					pos = 0;
					while (pos < n_loaded && m_weight[pos] >= w)
						pos++;
					for (int i = n_loaded; i > pos; i--) begin
						m_weight[i] = m_weight[i-1];
						m_members[i] = m_members[i-1];
						m_ident[i] = m_ident[i-1];
					end
					m_weight[pos] = w;
					m_members[pos] = q.count;
					m_ident[pos] = q.id;
					n_loaded++;
					draw_pos = '0;
				end
			end
			MODE_TALLY: o.tally = tallies[q.id];
			MODE_DRAW: begin
				if (sample_pos >= stt) begin
					o.status = STATUS_NOMASS;
				end else begin
					rem = mass_left;
					if (draw_pos == 0) begin
						for (int i = 0; i < n_loaded; i++) begin
							w_weight[i] = m_weight[i];
							w_members[i] = m_members[i];
							w_ident[i] = m_ident[i];
						end
						rem = WONE;
					end
					prod = rem * q.frac;
					target = prod[64:32];
					acc = '0;
					found = 0;
					anynz = 0;
					sel = 0;
					lastnz = 0;
					for (int j = 0; j < n_loaded; j++) begin
						if (w_weight[j] != 0) begin
							anynz = 1;
							lastnz = j;
							acc += w_weight[j];
							if (!found && target <= acc) begin
								found = 1;
								sel = j;
							end
						end
					end
					if (!anynz) begin
						o.status = STATUS_NOMASS;
					end else begin
						if (!found)
							sel = lastnz;
						w = w_weight[sel];
						m = w_members[sel];
						share = m != 0 ? w / m : w;
						w_weight[sel] = w - share;
						if (m != 0)
							w_members[sel] = m - 1;
						rem = rem > share ? rem - share : '0;
						mass_left = rem;
						cid = w_ident[sel];
						if (sel + 1 < n_loaded && w_weight[sel] < w_weight[sel+1]) begin
							tw = w_weight[sel];
							tm = w_members[sel];
							ti = w_ident[sel];
							w_weight[sel] = w_weight[sel+1];
							w_members[sel] = w_members[sel+1];
							w_ident[sel] = w_ident[sel+1];
							w_weight[sel+1] = tw;
							w_members[sel+1] = tm;
							w_ident[sel+1] = ti;
						end
						if (tallies[cid] != '1)
							tallies[cid]++;
						o.tally = tallies[cid];
						o.picked = cid;
						draw_pos = draw_pos + 1;
						if (draw_pos == 0 || draw_pos >= dps) begin
							o.last_draw = 1'b1;
							draw_pos = '0;
							sample_pos = sample_pos + 1;
							if (sample_pos >= stt)
								o.last_sample = 1'b1;
						end
					end
				end
			end
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("MISMATCH %s: got %0h, want %0h (result %0d, t=%0t)",
			what, got, want, results_cnt, $time);
	endtask

	// request driver
	int gap = 0;
	bit burst = 0;
	always @(negedge clk) begin
		if (arst_n && sent_cnt == accepted_cnt) begin
			if (gap > 0) begin
				gap <= gap - 1;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				request_t q;
				q = pending_reqs.pop_front();
				mode <= q.mode;
				class_id <= q.id;
				class_weight <= q.weight;
				class_count <= q.count;
				random_fraction <= q.frac;
				in_valid <= 1'b1;
				sent_cnt <= sent_cnt + 1;
				if ($urandom_range(0, 49) == 0)
					burst = ~burst;
				gap <= burst ? 0 : $urandom_range(0, 6);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// input acceptance and prediction
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			request_t q;
			q.mode = mode_t'(mode);
			q.id = class_id;
			q.weight = class_weight;
			q.count = class_count;
			q.frac = random_fraction;
			expected_outcomes.push_back(predict_sampler(q));
			accepted_cnt <= accepted_cnt + 1;
		end
	end

	// result stall generator, with one long hold-off to back up the input
	int hold = 0;
	int stall_seen = 0;
	bit long_done = 0;
	always @(negedge clk) begin
		if (results_cnt != stall_seen) begin
			stall_seen = results_cnt;
			if (hold == 0 && $urandom_range(0, 3) != 0)
				hold = $urandom_range(0, 6);
		end
		if (!long_done && results_cnt == 300) begin
			long_done = 1;
			hold = LONG_HOLD;
		end
		if (hold > 0) begin
			hold = hold - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_outcomes.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				outcome_t e;
				e = expected_outcomes.pop_front();
				if (picked_class !== e.picked)
					report_mismatch("picked_class", picked_class, e.picked);
				if (tally_count !== e.tally)
					report_mismatch("tally_count", tally_count, e.tally);
				if (status !== e.status)
					report_mismatch("status", status, e.status);
				if (last_draw !== e.last_draw)
					report_mismatch("last_draw", last_draw, e.last_draw);
				if (last_sample !== e.last_sample)
					report_mismatch("last_sample", last_sample, e.last_sample);
				if (e.status == STATUS_NOMASS) n_nomass++;
				if (e.status == STATUS_FULL) n_full++;
				if (e.last_sample) n_last_sample++;
			end
			results_cnt <= results_cnt + 1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout with %0d results outstanding", expected_outcomes.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic logic [32:0] rand_weight();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return WONE;
			2: return {1'b1, 32'($urandom)};
			3: return 33'($urandom_range(1, 255));
			default: return {1'b0, 32'($urandom) >> $urandom_range(0, 8)};
		endcase
	endfunction

	function automatic logic [15:0] rand_count();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(1, 6));
		endcase
	endfunction

	function automatic logic [31:0] rand_frac();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_req(mode_t md, logic [5:0] id, logic [32:0] w, logic [15:0] c,
			logic [31:0] f);
		request_t q;
		q.mode = md;
		q.id = id;
		q.weight = w;
		q.count = c;
		q.frac = f;
		pending_reqs.push_back(q);
		if (md == MODE_DRAW) n_picks++;
		if (md == MODE_LOAD) n_loads++;
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || sent_cnt != accepted_cnt
				|| expected_outcomes.size() > 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DPS)
			draws_cfg = val;
		else
			samples_cfg = val;
	endtask

	function automatic logic [15:0] rand_reg();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(1, 5));
		endcase
	endfunction

	initial begin
		int total, n, ndraw;
		clear_sampler();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed
		push_req(MODE_TALLY, 6'd63, '0, '0, '0);
		push_req(MODE_DRAW, 6'd0, '0, '0, 32'h8000_0000);
		push_req(MODE_LOAD, 6'd5, 33'h1_FFFF_FFFF, 16'd0, '0);
		push_req(MODE_DRAW, 6'd0, '0, '0, 32'hFFFF_FFFF);
		push_req(MODE_DRAW, 6'd0, '0, '0, '0);
		push_req(MODE_CLEAR, '0, '0, '0, '0);
		push_req(MODE_LOAD, 6'd1, 33'h0_4000_0000, 16'd2, '0);
		push_req(MODE_LOAD, 6'd2, 33'h0_4000_0000, 16'hFFFF, '0);
		push_req(MODE_LOAD, 6'd1, 33'h0_8000_0000, 16'd3, '0);
		push_req(MODE_LOAD, 6'd0, 33'd0, 16'd1, '0);
		push_req(MODE_DRAW, 6'd0, '0, '0, '0);
		push_req(MODE_DRAW, 6'd0, '0, '0, 32'hFFFF_FFFF);
		push_req(MODE_TALLY, 6'd1, '0, '0, '0);
		push_req(MODE_TALLY, 6'd2, '0, '0, '0);
		push_req(MODE_CLEAR, '0, '0, '0, '0);
		push_req(MODE_LOAD, 6'd9, '0, 16'd4, '0);
		push_req(MODE_DRAW, 6'd0, '0, '0, 32'h1234_5678);
		push_req(MODE_TALLY, 6'd9, '0, '0, '0);
		wait_idle();

		write_reg(REG_DPS, 16'd3);
		write_reg(REG_SAMPLES, 16'd2);
		total = 0;
		while (total < 1830) begin
			if ($urandom_range(0, 3) == 0) begin
				wait_idle();
				write_reg(REG_DPS, rand_reg());
				write_reg(REG_SAMPLES, rand_reg());
			end
			push_req(MODE_CLEAR, '0, '0, '0, '0);
			n = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				push_req(MODE_LOAD, 6'($urandom), rand_weight(), rand_count(), '0);
			ndraw = $urandom_range(3, 30);
			for (int i = 0; i < ndraw; i++) begin
				case ($urandom_range(0, 19))
					0: push_req(MODE_TALLY, 6'($urandom), '0, '0, '0);
					1: push_req(MODE_LOAD, 6'($urandom), rand_weight(), rand_count(), '0);
					2: push_req(MODE_CLEAR, '0, '0, '0, '0);
					default: push_req(MODE_DRAW, 6'($urandom), rand_weight(), rand_count(),
						rand_frac());
				endcase
			end
			push_req(MODE_TALLY, 6'($urandom), '0, '0, '0);
			total += n + ndraw + 2;
		end

		wait_idle();
		write_reg(REG_DPS, 16'hFFFF);
		write_reg(REG_SAMPLES, 16'hFFFF);
		push_req(MODE_LOAD, 6'd7, 33'h0_0001_0000, 16'd1, '0);
		push_req(MODE_DRAW, 6'd0, '0, '0, 32'hFFFF_FFFF);
		push_req(MODE_DRAW, 6'd0, '0, '0, 32'h0);
		wait_idle();

		$display("covered %0d requests: %0d loads, %0d draws, %0d results checked",
			accepted_cnt, n_loads, n_picks, results_cnt);
		$display("status no-mass/done %0d, table full %0d, final-sample flags %0d",
			n_nomass, n_full, n_last_sample);
		if (errors == 0 && expected_outcomes.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
